// File: rtl/tccw_pkg.sv
// Shared types and constants of the text console cell writer.
package tccw_pkg;

	localparam logic [7:0]  NEWLINE_CODE    = 8'h0A;
	localparam logic [7:0]  SPACE_CODE      = 8'h20;
	localparam logic [15:0] RESET_CELL      = 16'h0720;
	localparam logic [7:0]  RESET_ATTRIBUTE = 8'h07;

	typedef enum logic {
		ACT_PUT  = 1'b0,
		ACT_READ = 1'b1
	} action_t;

	// Commands from the sequencer to the address walker
	typedef struct packed {
		logic load;     // take the start address
		logic advance;  // step to the next address
	} walk_ctl_t;

endpackage

// File: rtl/tccw_ram.sv
// Generic single write port, single read port RAM with registered read data.
module tccw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/tccw_walker.sv
// Shared address walker: one counter and adder stepped through the screen memory.
module tccw_walker #(
	parameter int COLUMNS = 80,
	parameter int AW      = 11
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tccw_pkg::walk_ctl_t ctl,
	input  logic [AW-1:0]       start,
	input  logic [AW-1:0]       stop,
	output logic [AW-1:0]       addr,
	output logic [AW-1:0]       src,
	output logic                last
);
	import tccw_pkg::*;

	logic [AW-1:0] cnt_q;
	logic [AW:0]   src_sum;

	// Source of a row copy sits one row further down
	assign src_sum = {1'b0, cnt_q} + (AW+1)'(COLUMNS);
	assign src     = src_sum[AW-1:0];
	assign addr    = cnt_q;
	assign last    = (cnt_q == stop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.load) begin
			cnt_q <= start;
		end else if (ctl.advance) begin
			cnt_q <= cnt_q + AW'(1);
		end
	end

endmodule

// File: rtl/text_console_cell_writer_core.sv
// Top level of the text console cell writer: sequencer, cursor and screen memory.
//
//  channel   direction  handshake                       payload
//  s_axis    in         s_axis_tvalid / s_axis_tready   tuser: action; tdata: char, address
//  m_axis    out        m_axis_tvalid / m_axis_tready   tdata: cursor, read data, scrolled
//  cfg       in         cfg_valid / cfg_ready           cfg_data: text attribute
//
//  After reset a clearing pass writes the blank cell to all ROWS*COLUMNS entries, one per
//  cycle, before s_axis_tready first rises; cfg writes are taken throughout.
//  A put item goes from the idle step through the finish step to the result register; an
//  in-range read waits in the read wait step first. A scrolling put passes the copy and fill
//  steps: the walker copies rows 1..ROWS-1 up one row, then blanks the last row.
//  One item is in flight at a time; a result waiting on m_axis_tready holds the sequencer
//  in its finish step, and s_axis_tready stays low until the result is loaded.
module text_console_cell_writer_core #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // [7:0] char_code, [18:8] read_address, rest zero
	input  logic [0:0]  s_axis_tuser,  // [0] action
	// result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [10:0] cursor_position, [17:11] cursor_column,
	                                   // [22:18] cursor_row, [38:23] read_data, [39] scrolled
	// attribute register
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);
	import tccw_pkg::*;

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int AW = $clog2(CELL_COUNT);
	localparam int CW = $clog2(COLUMNS);
	localparam int RW = $clog2(ROWS);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RDWAIT,
		ST_COPY,
		ST_FILL,
		ST_FINISH
	} state_t;

	state_t state_q;

	// cursor: column, row, start of row and linear position
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [AW-1:0] line_q;
	logic [AW-1:0] pos_q;
	logic [7:0]    attr_q;

	// result being assembled
	logic [15:0]   rd_q;
	logic          scr_q;

	// memory write stage shared by clear, copy and fill
	logic          wr_valid_s1;
	logic [AW-1:0] wr_addr_s1;
	logic [15:0]   wr_data_s1;
	logic          wr_from_ram_s1;

	// walker
	walk_ctl_t     walk_ctl;
	logic [AW-1:0] walk_start;
	logic [AW-1:0] walk_stop;
	logic [AW-1:0] walk_addr;
	logic [AW-1:0] walk_src;
	logic          walk_last;

	// memory ports
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [15:0]   ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [15:0]   ram_rdata;

	// input fields
	action_t       in_action;
	logic [7:0]    in_char;
	logic [31:0]   in_addr32;
	logic          in_range;
	logic          accept;
	logic          put_char;
	logic          row_end;
	logic          last_row;
	logic          advance_row;
	logic          out_free;

	// output field views
	logic [31:0]   pos32;
	logic [31:0]   col32;
	logic [31:0]   row32;

	assign in_action = action_t'(s_axis_tuser[0]);
	assign in_char   = s_axis_tdata[7:0];
	assign in_addr32 = 32'(s_axis_tdata[18:8]);
	assign in_range  = (in_addr32 < 32'(CELL_COUNT));

	// Hold off new items while the write stage still drains
	assign s_axis_tready = (state_q == ST_IDLE) && !wr_valid_s1;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign put_char      = accept && (in_action == ACT_PUT) && (in_char != NEWLINE_CODE);
	assign row_end       = (col_q == CW'(COLUMNS - 1));
	assign last_row      = (row_q == RW'(ROWS - 1));
	assign advance_row   = (in_char == NEWLINE_CODE) || row_end;
	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign cfg_ready     = 1'b1;

	// Walker control per sequencer step
	always_comb begin
		walk_ctl   = '0;
		walk_start = '0;
		walk_stop  = AW'(CELL_COUNT - 1);
		case (state_q)
			ST_CLEAR: begin
				walk_ctl.advance = !walk_last;
			end
			ST_IDLE: begin
				walk_ctl.load = 1'b1;
			end
			ST_COPY: begin
				walk_stop = AW'(CELL_COUNT - COLUMNS - 1);
				if (walk_last) begin
					walk_ctl.load = 1'b1;
					walk_start    = AW'(CELL_COUNT - COLUMNS);
				end else begin
					walk_ctl.advance = 1'b1;
				end
			end
			ST_FILL: begin
				walk_ctl.advance = !walk_last;
			end
			default: begin
				walk_ctl = '0;
			end
		endcase
	end

	tccw_walker #(
		.COLUMNS (COLUMNS),
		.AW      (AW)
	) u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (walk_ctl),
		.start  (walk_start),
		.stop   (walk_stop),
		.addr   (walk_addr),
		.src    (walk_src),
		.last   (walk_last)
	);

	// Memory write: the stage owns the port; a put character writes only when it is idle
	assign ram_we    = wr_valid_s1 || put_char;
	assign ram_waddr = wr_valid_s1 ? wr_addr_s1 : pos_q;
	assign ram_wdata = wr_valid_s1 ? (wr_from_ram_s1 ? ram_rdata : wr_data_s1)
	                               : {attr_q, in_char};
	assign ram_raddr = (state_q == ST_COPY) ? walk_src : in_addr32[AW-1:0];

	tccw_ram #(
		.WIDTH (16),
		.DEPTH (CELL_COUNT)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Write stage payload
	always_ff @(posedge clk) begin
		wr_addr_s1     <= walk_addr;
		wr_from_ram_s1 <= (state_q == ST_COPY);
		wr_data_s1     <= (state_q == ST_CLEAR) ? RESET_CELL : {attr_q, SPACE_CODE};
	end

	assign pos32 = 32'(pos_q);
	assign col32 = 32'(col_q);
	assign row32 = 32'(row_q);

	// Sequencer, cursor and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			wr_valid_s1   <= 1'b0;
			col_q         <= '0;
			row_q         <= '0;
			line_q        <= '0;
			pos_q         <= '0;
			attr_q        <= RESET_ATTRIBUTE;
			rd_q          <= '0;
			scr_q         <= 1'b0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				attr_q <= cfg_data;
			end
			// the finish step reloads the register itself
			if (m_axis_tvalid && m_axis_tready && (state_q != ST_FINISH)) begin
				m_axis_tvalid <= 1'b0;
			end
			wr_valid_s1 <= (state_q == ST_CLEAR) || (state_q == ST_COPY)
			            || (state_q == ST_FILL);

			case (state_q)
				ST_CLEAR: begin
					if (walk_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						rd_q  <= '0;
						scr_q <= (in_action == ACT_PUT) && advance_row && last_row;
						if (in_action == ACT_READ) begin
							state_q <= in_range ? ST_RDWAIT : ST_FINISH;
						end else if (advance_row) begin
							col_q <= '0;
							if (last_row) begin
								// scroll: cursor stays at the start of the last row
								pos_q   <= line_q;
								state_q <= ST_COPY;
							end else begin
								row_q   <= row_q + RW'(1);
								line_q  <= line_q + AW'(COLUMNS);
								pos_q   <= line_q + AW'(COLUMNS);
								state_q <= ST_FINISH;
							end
						end else begin
							col_q   <= col_q + CW'(1);
							pos_q   <= pos_q + AW'(1);
							state_q <= ST_FINISH;
						end
					end
				end
				ST_RDWAIT: begin
					rd_q    <= ram_rdata;
					state_q <= ST_FINISH;
				end
				ST_COPY: begin
					if (walk_last) begin
						state_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					if (walk_last) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tdata  <= {scr_q, rd_q, row32[4:0], col32[6:0], pos32[10:0]};
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/tccw_checker.sv
// Port-level checks of the text console cell writer, bound to its top level.
module tccw_checker #(
	parameter int ROWS = 25
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata
);

	localparam logic [4:0] LAST_ROW = 5'((ROWS - 1) % 32);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// one item at a time: no transfer right after a transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready right after a transfer");

	// a scroll leaves the cursor at column 0 of the last row
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[39] |-> m_axis_tdata[17:11] == 7'd0
			&& m_axis_tdata[22:18] == LAST_ROW)
		else $error("scroll with cursor off the last row start");

	// read data only comes with read items, which never scroll
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[38:23] != 16'd0 |-> !m_axis_tdata[39])
		else $error("read data on a scrolling result");

endmodule

bind text_console_cell_writer_core tccw_checker #(
	.ROWS (ROWS)
) u_tccw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
